/* src/qstpd_pkg.sv */
`default_nettype none

package qstpd_pkg;

    localparam int CMD_W     = 17;   // signed speed command
    localparam int SPD_W     = 16;   // clamped magnitude, speed limit
    localparam int SQ_W      = 2 * SPD_W;
    localparam int DUTY_W    = 16;
    localparam int NUM_W     = SQ_W + DUTY_W;
    localparam int DIV_STEPS = DUTY_W;   // one quotient bit per stage

    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [SPD_W-1:0] SPEED_LIMIT_RESET = 16'd1000;

    // register index, taken from paddr[2]; byte offset bits are ignored
    localparam logic REG_SPEED_LIMIT = 1'b0;

    typedef logic [SQ_W-1:0]   t_sq;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [DUTY_W-1:0] t_duty;

endpackage

`default_nettype wire

/* src/quadratic_speed_to_pwm_duty.sv */
// Throughput: one beat per cycle; the whole pipeline holds while the output stalls.
// Stages: magnitude/clamp, two 16x16 squares, numerator build, then a
// 16-stage restoring divider giving one quotient bit per stage.
// Reset (synchronous, active low) empties the pipeline and sets speed_limit to 1000.
`default_nettype none

module quadratic_speed_to_pwm_duty (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire signed [qstpd_pkg::CMD_W-1:0]   i_speed_command,

    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [qstpd_pkg::DUTY_W-1:0]        o_duty,

    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [qstpd_pkg::ADDR_W-1:0]        paddr,
    input  wire  [qstpd_pkg::DATA_W-1:0]        pwdata,
    output logic [qstpd_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int N = qstpd_pkg::DIV_STEPS;

    // ---------------- configuration ----------------
    logic [qstpd_pkg::SPD_W-1:0] r_limit;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= qstpd_pkg::SPEED_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == qstpd_pkg::REG_SPEED_LIMIT) begin
            r_limit <= pwdata[qstpd_pkg::SPD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == qstpd_pkg::REG_SPEED_LIMIT) begin
            prdata = {{(qstpd_pkg::DATA_W - qstpd_pkg::SPD_W){1'b0}}, r_limit};
        end
    end

    // ---------------- pipeline control ----------------
    logic w_adv;
    logic r_v1, r_v2;
    logic [N:0] r_vld;

    assign w_adv   = !(r_vld[N] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vld <= '0;
        end else if (w_adv) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_vld <= {r_vld[N-1:0], r_v2};
        end
    end

    // ---------------- stage 1: magnitude and clamp ----------------
    logic [qstpd_pkg::CMD_W-1:0] w_mag;
    logic [qstpd_pkg::SPD_W-1:0] n_mag1, n_lim1;
    logic [qstpd_pkg::SPD_W-1:0] r_mag1, r_lim1;

    always_comb begin
        w_mag = i_speed_command[qstpd_pkg::CMD_W-1]
              ? (~i_speed_command + {{(qstpd_pkg::CMD_W-1){1'b0}}, 1'b1})
              : i_speed_command;
        if (w_mag > {1'b0, r_limit}) begin
            n_mag1 = r_limit;
        end else begin
            n_mag1 = w_mag[qstpd_pkg::SPD_W-1:0];
        end
        // zero limit: magnitude is already clamped to zero, divide 0 by 1
        n_lim1 = (r_limit == '0) ? {{(qstpd_pkg::SPD_W-1){1'b0}}, 1'b1} : r_limit;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mag1 <= n_mag1;
            r_lim1 <= n_lim1;
        end
    end

    // ---------------- stage 2: squares ----------------
    qstpd_pkg::t_sq r_msq2, r_den2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_msq2 <= {{qstpd_pkg::SPD_W{1'b0}}, r_mag1} * {{qstpd_pkg::SPD_W{1'b0}}, r_mag1};
            r_den2 <= {{qstpd_pkg::SPD_W{1'b0}}, r_lim1} * {{qstpd_pkg::SPD_W{1'b0}}, r_lim1};
        end
    end

    // ---------------- stage 3: numerator plus rounding ----------------
    // m^2 * 65535 = (m^2 << 16) - m^2, then add half the divisor
    qstpd_pkg::t_num n_num;
    qstpd_pkg::t_sq  r_rem [0:N];
    qstpd_pkg::t_duty r_nlo [0:N];
    qstpd_pkg::t_duty r_quo [0:N];
    qstpd_pkg::t_sq  r_den [0:N];

    always_comb begin
        n_num = {r_msq2, {qstpd_pkg::DUTY_W{1'b0}}}
              - {{qstpd_pkg::DUTY_W{1'b0}}, r_msq2}
              + {{(qstpd_pkg::DUTY_W + 1){1'b0}}, r_den2[qstpd_pkg::SQ_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem[0] <= n_num[qstpd_pkg::NUM_W-1:qstpd_pkg::DUTY_W];
            r_nlo[0] <= n_num[qstpd_pkg::DUTY_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= r_den2;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // quotient fits 16 bits, so the high numerator half is already below the divisor
    for (genvar k = 1; k <= N; k++) begin : g_div
        logic [qstpd_pkg::SQ_W:0] w_trial, w_diff;
        logic                     w_ge;
        qstpd_pkg::t_sq           n_rem;

        always_comb begin
            w_trial = {r_rem[k-1], r_nlo[k-1][qstpd_pkg::DUTY_W-1]};
            w_diff  = w_trial - {1'b0, r_den[k-1]};
            w_ge    = w_trial >= {1'b0, r_den[k-1]};
            n_rem   = w_ge ? w_diff[qstpd_pkg::SQ_W-1:0] : w_trial[qstpd_pkg::SQ_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[k] <= n_rem;
                r_nlo[k] <= {r_nlo[k-1][qstpd_pkg::DUTY_W-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][qstpd_pkg::DUTY_W-2:0], w_ge};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_duty = r_quo[N];

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output stage can move");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_duty)))
        else $error("stalled duty beat changed or vanished");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N/2] |-> (r_rem[N/2] < r_den[N/2]))
        else $error("divider remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_den[0] != '0))
        else $error("zero divisor entered divider");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted command lost at first stage");

endmodule

`default_nettype wire

/* sim/qstpd_checker.sv */
`timescale 1ns / 100ps

module qstpd_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 i_cmd_valid,
    input  wire                                 i_cmd_stall,
    input  wire signed [qstpd_pkg::CMD_W-1:0]   i_speed_command,

    input  wire                                 i_duty_valid,
    input  wire                                 i_duty_stall,
    input  wire [qstpd_pkg::DUTY_W-1:0]         i_duty,

    input  wire                                 i_psel,
    input  wire                                 i_penable,
    input  wire                                 i_pwrite,
    input  wire [qstpd_pkg::ADDR_W-1:0]         i_paddr,
    input  wire [qstpd_pkg::DATA_W-1:0]         i_pwdata,
    input  wire [qstpd_pkg::DATA_W-1:0]         i_prdata,
    input  wire                                 i_pready,

    output int                                  o_pending,
    output int                                  o_mismatches
);

    typedef struct {
        logic signed [qstpd_pkg::CMD_W-1:0] cmd;
        logic [qstpd_pkg::SPD_W-1:0]        limit;
        qstpd_pkg::t_duty                   duty;
    } t_duty_expect;

    t_duty_expect                pending_duties[$];
    logic [qstpd_pkg::SPD_W-1:0] speed_limit_model;
    int                          mismatch_count;

    // square law: clamp |cmd| to the limit, then round(mag^2 * 65535 / limit^2)
    function automatic qstpd_pkg::t_duty square_law_duty(
        input logic signed [qstpd_pkg::CMD_W-1:0] cmd,
        input logic [qstpd_pkg::SPD_W-1:0]        limit);
        logic [qstpd_pkg::CMD_W-1:0] mag;
        logic [63:0]                 num;
        logic [63:0]                 den;
        logic [63:0]                 quot;
        mag = cmd[qstpd_pkg::CMD_W-1] ? (~cmd + 1'b1) : cmd;   // -65536 gives 65536
        if (limit == '0)
            return '0;
        if (mag > {1'b0, limit})
            mag = {1'b0, limit};
        num  = 64'(mag) * 64'(mag) * 64'd65535;
        den  = 64'(limit) * 64'(limit);
        quot = (num + den / 2) / den;
        return quot[qstpd_pkg::DUTY_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_duty_expect head;
        t_duty_expect entry;
        if (!i_rst_n) begin
            pending_duties.delete();
            speed_limit_model = qstpd_pkg::SPEED_LIMIT_RESET;
        end else begin
            if (i_duty_valid && !i_duty_stall) begin
                if (pending_duties.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: duty beat %0d with nothing expected (expected none, got %0d)",
                             $time, i_duty, i_duty);
                end else begin
                    head = pending_duties.pop_front();
                    if (i_duty !== head.duty) begin
                        mismatch_count++;
                        $display("%0t: duty for command %0d, limit %0d: expected %0d, got %0d",
                                 $time, head.cmd, head.limit, head.duty, i_duty);
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                entry.cmd   = i_speed_command;
                entry.limit = speed_limit_model;
                entry.duty  = square_law_duty(i_speed_command, speed_limit_model);
                pending_duties.push_back(entry);
            end
            if (i_psel && i_penable && i_pready
                && i_paddr[2] == qstpd_pkg::REG_SPEED_LIMIT) begin
                if (i_pwrite) begin
                    speed_limit_model = i_pwdata[qstpd_pkg::SPD_W-1:0];
                end else if (i_prdata !== {{(qstpd_pkg::DATA_W - qstpd_pkg::SPD_W){1'b0}},
                                           speed_limit_model}) begin
                    mismatch_count++;
                    $display("%0t: speed_limit read: expected %0d, got %0d",
                             $time, speed_limit_model, i_prdata);
                end
            end
        end
        o_pending    <= pending_duties.size();
        o_mismatches <= mismatch_count;
    end

endmodule

/* sim/quadratic_speed_to_pwm_duty_tb.sv */
`timescale 1ns / 100ps

module quadratic_speed_to_pwm_duty_tb;

    localparam logic [qstpd_pkg::ADDR_W-1:0] ADDR_SPEED_LIMIT =
        {qstpd_pkg::REG_SPEED_LIMIT, 2'b00};
    localparam logic [qstpd_pkg::ADDR_W-1:0] ADDR_UNMAPPED    =
        {~qstpd_pkg::REG_SPEED_LIMIT, 2'b00};
    localparam int RANDOM_LIMIT   = -1;      // phase picks a random limit from 3 to 65533
    localparam int CMDS_PER_PHASE = 88;
    localparam int NUM_PHASES     = 12;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic signed [qstpd_pkg::CMD_W-1:0] i_speed_command = '0;
    logic                               i_stall = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [qstpd_pkg::ADDR_W-1:0]       paddr = '0;
    logic [qstpd_pkg::DATA_W-1:0]       pwdata = '0;

    wire                                o_stall;
    wire                                o_valid;
    wire [qstpd_pkg::DUTY_W-1:0]        o_duty;
    wire [qstpd_pkg::DATA_W-1:0]        prdata;
    wire                                pready;

    int pending;
    int mismatches;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cmds_sent = 0;
    int limits_used = 0;
    logic [qstpd_pkg::SPD_W-1:0] cur_limit = qstpd_pkg::SPEED_LIMIT_RESET;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    quadratic_speed_to_pwm_duty u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_speed_command (i_speed_command),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_duty          (o_duty),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    qstpd_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_valid),
        .i_cmd_stall     (o_stall),
        .i_speed_command (i_speed_command),
        .i_duty_valid    (o_valid),
        .i_duty_stall    (i_stall),
        .i_duty          (o_duty),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    task automatic write_reg(input logic [qstpd_pkg::ADDR_W-1:0] addr,
                             input logic [qstpd_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input logic [qstpd_pkg::ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // valid stays high across back-to-back beats; an idle gap lowers it before the next beat
    task automatic drive_command(input logic signed [qstpd_pkg::CMD_W-1:0] cmd);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_speed_command <= cmd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cmds_sent++;
    endtask

    // mostly magnitudes up to just past the limit, where the curve is not saturated
    function automatic logic signed [qstpd_pkg::CMD_W-1:0] pick_command(
        input logic [qstpd_pkg::SPD_W-1:0] limit);
        int sel;
        int mag;
        sel = $urandom_range(99);
        if (sel < 30)
            return qstpd_pkg::CMD_W'($urandom());
        if (sel < 80) begin
            mag = $urandom_range(int'(limit) + 2, 0);
        end else begin
            case ($urandom_range(5))
                0:       mag = 0;
                1:       mag = 65536;
                2:       mag = 65535;
                3:       mag = int'(limit);
                4:       mag = int'(limit) + 1;
                default: mag = int'(limit) - 1;
            endcase
        end
        return qstpd_pkg::CMD_W'($urandom_range(1) ? -mag : mag);
    endfunction

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    initial begin
        int directed[] = '{0, 1, -1, 500, -500, 999, -999, 1000, -1000, 1001, -1001,
                           65535, -65535, -65536, 32767, -32768, 43690, -43691, 707, -708};
        int limits[] = '{1000, 0, 65535, 1, 2, 65534, 255, 256,
                         RANDOM_LIMIT, RANDOM_LIMIT, RANDOM_LIMIT, 1000};
        int lim;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value must survive a write to the unmapped slot
        read_reg(ADDR_SPEED_LIMIT);
        write_reg(ADDR_UNMAPPED, $urandom());
        read_reg(ADDR_SPEED_LIMIT);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            if (p > 0) begin
                lim = (limits[p] == RANDOM_LIMIT) ? $urandom_range(65533, 3) : limits[p];
                // upper data bits are junk; only the low 16 land in the register
                write_reg(ADDR_SPEED_LIMIT, {16'($urandom_range(65535)), 16'(lim)});
                read_reg(ADDR_SPEED_LIMIT);
                cur_limit = 16'(lim);
            end
            limits_used++;
            if (p == 0) begin
                foreach (directed[k]) drive_command(qstpd_pkg::CMD_W'(directed[k]));
            end
            repeat (CMDS_PER_PHASE) drive_command(pick_command(cur_limit));
            i_valid <= 1'b0;
            wait_drained();
        end

        stall_pct = 0;
        repeat (40) @(posedge i_clk);
        $display("Sent %0d speed commands over %0d speed_limit settings (zero, one, full scale,",
                 cmds_sent, limits_used);
        $display("random) with idle-free, sender-gap, receiver-stall and mixed flow control.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d duty beats outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule
